// File: hdl/lppf_pkg.sv
// ----------------------------------------------------------------------------
// lppf_pkg: shared types and constants for the lidar point projection filter
// Register indexes, field widths and fixed-point formats.
// ----------------------------------------------------------------------------
package lppf_pkg;

  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned INTEN_W    = 8;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned PROD_W     = COEF_W + COORD_W;   // exact product
  localparam int unsigned OFF_W      = COEF_W + 7;         // offset scaled by 2^7
  localparam int unsigned PSUM_W     = PROD_W + 1;
  localparam int unsigned ACC_W      = PROD_W + 2;         // exact sum of four terms
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned LIM_W      = ACC_W + DIM_W + 2;  // w * (2*dim - 1)

  typedef logic [IDX_W-1:0]            reg_idx_t;
  typedef logic [CFG_W-1:0]            cfg_word_t;
  typedef logic signed [COORD_W-1:0]   coord_t;
  typedef logic [INTEN_W-1:0]          inten_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [OFF_W-1:0]     off_t;
  typedef logic signed [PSUM_W-1:0]    psum_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [LIM_W-1:0]     lim_t;
  typedef logic [DIM_W-1:0]            dim_t;

  localparam reg_idx_t REG_ROW0_AB = 4'd0;
  localparam reg_idx_t REG_ROW0_CD = 4'd1;
  localparam reg_idx_t REG_ROW1_AB = 4'd2;
  localparam reg_idx_t REG_ROW1_CD = 4'd3;
  localparam reg_idx_t REG_ROW2_AB = 4'd4;
  localparam reg_idx_t REG_ROW2_CD = 4'd5;
  localparam reg_idx_t REG_ROI     = 4'd6;
  localparam reg_idx_t REG_IMAGE   = 4'd7;

  // Carried point payload.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    inten_t inten;
  } point_t;

endpackage

// File: hdl/lidar_point_project_filter.sv
// ----------------------------------------------------------------------------
// lidar_point_project_filter: camera projection and region filter for points
// Projects each lidar point through a 3x4 matrix and keeps it when it lands
// inside the image and inside the x/y region of interest.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one point per transfer, valid/ready handshake.
//   Result channel (out_*): a point that passed every test, unchanged.
//   Dropped points produce no transfer at all.
//   Configuration (cfg_*): write-only; write only while no point is in flight.
//   Throughput: one point per cycle while the output is not stalled; the
//     pipeline is four compute stages (multiply, pair add, final add, depth
//     scaling) and the output register, from which a kept point appears.
//   Stall: when the output register is full and out_ready is low, the whole
//     pipeline holds and in_ready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous): empties the pipeline and clears all
//     configuration registers to zero, so no point passes until loaded.
//   Pixel tests are done without a divider: round(u/w) in [0, cols) with
//   ties to even is 2u >= -w and (2u < (2cols-1)w, or equal with cols odd).
// ----------------------------------------------------------------------------
module lidar_point_project_filter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  lppf_pkg::reg_idx_t       cfg_index,
  input  lppf_pkg::cfg_word_t      cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  lppf_pkg::coord_t         in_point_x,
  input  lppf_pkg::coord_t         in_point_y,
  input  lppf_pkg::coord_t         in_point_z,
  input  lppf_pkg::inten_t         in_point_intensity,
  output logic                     out_valid,
  input  logic                     out_ready,
  output lppf_pkg::coord_t         out_kept_x,
  output lppf_pkg::coord_t         out_kept_y,
  output lppf_pkg::coord_t         out_kept_z,
  output lppf_pkg::inten_t         out_kept_intensity
);
  import lppf_pkg::*;

  // Configuration registers.
  cfg_word_t regs_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_we && (cfg_index < reg_idx_t'(NUM_REGS))) begin
      if (cfg_index == REG_IMAGE) begin
        regs_r[cfg_index[2:0]] <= {40'd0, cfg_data[23:0]};
      end else begin
        regs_r[cfg_index[2:0]] <= cfg_data;
      end
    end
  end

  // Decode fields of the configuration.
  coef_t  coef [3][4];
  coord_t x_min, x_max, y_min, y_max;
  dim_t   cols, rows;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = coef_t'(regs_r[2*r][31:0]);
      coef[r][1] = coef_t'(regs_r[2*r][63:32]);
      coef[r][2] = coef_t'(regs_r[2*r+1][31:0]);
      coef[r][3] = coef_t'(regs_r[2*r+1][63:32]);
    end
    x_min = coord_t'(regs_r[REG_ROI[2:0]][15:0]);
    x_max = coord_t'(regs_r[REG_ROI[2:0]][31:16]);
    y_min = coord_t'(regs_r[REG_ROI[2:0]][47:32]);
    y_max = coord_t'(regs_r[REG_ROI[2:0]][63:48]);
    cols  = regs_r[REG_IMAGE[2:0]][11:0];
    rows  = regs_r[REG_IMAGE[2:0]][23:12];
  end

  // Global advance: the whole pipe moves unless the output is full and stalled.
  logic adv;
  logic out_valid_r;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  point_t pt_in;
  assign pt_in = '{x: in_point_x, y: in_point_y, z: in_point_z, inten: in_point_intensity};

  // Stage 1: nine products, scaled offsets, region test.
  logic   s1_v_r;
  point_t s1_pt_r;
  logic   s1_roi_r;
  prod_t  s1_p_r [3][3];
  off_t   s1_off_r [3];

  // Stage 2: pairwise sums.
  logic   s2_v_r;
  point_t s2_pt_r;
  logic   s2_roi_r;
  psum_t  s2_a_r [3];
  psum_t  s2_b_r [3];

  // Stage 3: u, v, w.
  logic   s3_v_r;
  point_t s3_pt_r;
  logic   s3_roi_r;
  acc_t   s3_acc_r [3];

  // Stage 4: depth-scaled limits and the lower-bound tests.
  logic   s4_v_r;
  point_t s4_pt_r;
  logic   s4_ok_r;
  lim_t   s4_u2_r, s4_v2_r, s4_lim_c_r, s4_lim_r_r;

  // Output register.
  point_t out_pt_r;

  logic roi_ok;
  assign roi_ok = (in_point_x > x_min) && (in_point_x < x_max) &&
                  (in_point_y > y_min) && (in_point_y < y_max);

  // Stage 4 combinational pieces.
  acc_t s3_w;
  lim_t w_ext, u2, v2, lim_c, lim_r;
  logic lo_ok;
  assign s3_w  = s3_acc_r[2];
  assign w_ext = lim_t'(s3_w);
  assign u2    = lim_t'(s3_acc_r[0]) <<< 1;
  assign v2    = lim_t'(s3_acc_r[1]) <<< 1;
  assign lim_c = w_ext * lim_t'({1'b0, cols, 1'b0} - 14'd1);
  assign lim_r = w_ext * lim_t'({1'b0, rows, 1'b0} - 14'd1);
  assign lo_ok = (s3_w > acc_t'(0)) && (u2 + w_ext >= lim_t'(0)) &&
                 (v2 + w_ext >= lim_t'(0));

  // Stage 5 decision.
  logic hi_ok, pass;
  assign hi_ok = ((s4_u2_r < s4_lim_c_r) || ((s4_u2_r == s4_lim_c_r) && cols[0])) &&
                 ((s4_v2_r < s4_lim_r_r) || ((s4_v2_r == s4_lim_r_r) && rows[0]));
  assign pass  = s4_v_r && s4_ok_r && hi_ok;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= in_valid;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      s4_v_r      <= s3_v_r;
      out_valid_r <= pass;
    end
  end

  // Datapath; advance with the valid bits.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pt_r  <= pt_in;
      s1_roi_r <= roi_ok;
      for (int r = 0; r < 3; r++) begin
        s1_p_r[r][0] <= coef[r][0] * prod_t'(in_point_x);
        s1_p_r[r][1] <= coef[r][1] * prod_t'(in_point_y);
        s1_p_r[r][2] <= coef[r][2] * prod_t'(in_point_z);
        s1_off_r[r]  <= off_t'(coef[r][3]) <<< 7;
      end

      s2_pt_r  <= s1_pt_r;
      s2_roi_r <= s1_roi_r;
      for (int r = 0; r < 3; r++) begin
        s2_a_r[r] <= psum_t'(s1_p_r[r][0]) + psum_t'(s1_p_r[r][1]);
        s2_b_r[r] <= psum_t'(s1_p_r[r][2]) + psum_t'(s1_off_r[r]);
      end

      s3_pt_r  <= s2_pt_r;
      s3_roi_r <= s2_roi_r;
      for (int r = 0; r < 3; r++) begin
        s3_acc_r[r] <= acc_t'(s2_a_r[r]) + acc_t'(s2_b_r[r]);
      end

      s4_pt_r    <= s3_pt_r;
      s4_ok_r    <= s3_roi_r && lo_ok;
      s4_u2_r    <= u2;
      s4_v2_r    <= v2;
      s4_lim_c_r <= lim_c;
      s4_lim_r_r <= lim_r;

      if (pass) out_pt_r <= s4_pt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kept_x         = out_pt_r.x;
  assign out_kept_y         = out_pt_r.y;
  assign out_kept_z         = out_pt_r.z;
  assign out_kept_intensity = out_pt_r.inten;

endmodule

// File: hdl/lppf_checker.sv
// ----------------------------------------------------------------------------
// lppf_sva: port-level checks for the lidar point projection filter
// Watches reset, stall and output holding behavior.
// ----------------------------------------------------------------------------
module lppf_sva (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lppf_pkg::coord_t    out_kept_x,
  input lppf_pkg::coord_t    out_kept_y,
  input lppf_pkg::coord_t    out_kept_z,
  input lppf_pkg::inten_t    out_kept_intensity
);
  import lppf_pkg::*;

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // A stalled full output blocks new input.
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // An empty output always takes input.
  a_free_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kept_x) &&
    $stable(out_kept_y) && $stable(out_kept_z) && $stable(out_kept_intensity))
    else $error("stalled result changed");

endmodule

bind lidar_point_project_filter lppf_sva u_lppf_sva (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_kept_x         (out_kept_x),
  .out_kept_y         (out_kept_y),
  .out_kept_z         (out_kept_z),
  .out_kept_intensity (out_kept_intensity)
);

// File: bench/lppf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lppf_checker: result checker for the lidar point projection filter
// Tracks register writes, predicts which accepted points survive the
// projection, pixel and region tests, and compares every result transfer.
// ----------------------------------------------------------------------------
module lppf_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  lppf_pkg::reg_idx_t  cfg_index,
  input  lppf_pkg::cfg_word_t cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  lppf_pkg::coord_t    in_point_x,
  input  lppf_pkg::coord_t    in_point_y,
  input  lppf_pkg::coord_t    in_point_z,
  input  lppf_pkg::inten_t    in_point_intensity,
  input  logic                out_valid,
  input  logic                out_ready,
  input  lppf_pkg::coord_t    out_kept_x,
  input  lppf_pkg::coord_t    out_kept_y,
  input  lppf_pkg::coord_t    out_kept_z,
  input  lppf_pkg::inten_t    out_kept_intensity,
  output int                  fail_count,
  output int                  kept_pending
);
  import lppf_pkg::*;

  cfg_word_t camera_regs [NUM_REGS];
  point_t    kept_points [$];

  // coef0*x + coef1*y + coef2*z + offset*128, all exact in 64 bits
  function automatic longint project_row(int r, coord_t x, coord_t y, coord_t z);
    cfg_word_t ab;
    cfg_word_t cd;
    ab = camera_regs[3'(2*r)];
    cd = camera_regs[3'(2*r+1)];
    return longint'(coef_t'(ab[31:0])) * longint'(x)
         + longint'(coef_t'(ab[63:32])) * longint'(y)
         + longint'(coef_t'(cd[31:0])) * longint'(z)
         + longint'(coef_t'(cd[63:32])) * 128;
  endfunction

  // nearest integer to n/w with ties to even, w > 0
  function automatic longint round_pixel(longint n, longint w);
    longint q;
    longint rem;
    q = n / w;
    rem = n - q * w;
    if (rem < 0) begin
      q = q - 1;
      rem = rem + w;
    end
    if (2 * rem > w || (2 * rem == w && q[0])) q = q + 1;
    return q;
  endfunction

  function automatic bit point_survives(coord_t x, coord_t y, coord_t z);
    longint depth;
    longint col;
    longint row;
    longint cols;
    longint rows;
    cfg_word_t roi;
    cols = longint'(camera_regs[REG_IMAGE[2:0]][11:0]);
    rows = longint'(camera_regs[REG_IMAGE[2:0]][23:12]);
    roi = camera_regs[REG_ROI[2:0]];
    depth = project_row(2, x, y, z);
    if (depth <= 0) return 1'b0;
    col = round_pixel(project_row(0, x, y, z), depth);
    row = round_pixel(project_row(1, x, y, z), depth);
    if (col < 0 || col >= cols || row < 0 || row >= rows) return 1'b0;
    return x > coord_t'(roi[15:0]) && x < coord_t'(roi[31:16]) &&
           y > coord_t'(roi[47:32]) && y < coord_t'(roi[63:48]);
  endfunction

  always @(posedge clk) begin
    point_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) camera_regs[i] = '0;
      kept_points.delete();
      fail_count = 0;
    end else begin
      // mirror register writes; indexes past the last register are dropped
      if (cfg_we && cfg_index < NUM_REGS)
        camera_regs[cfg_index[2:0]] = (cfg_index == REG_IMAGE) ?
                                      (cfg_data & 64'hFF_FFFF) : cfg_data;
      if (in_valid && in_ready &&
          point_survives(in_point_x, in_point_y, in_point_z))
        kept_points.insert(kept_points.size(), '{in_point_x, in_point_y, in_point_z,
                                                 in_point_intensity});
      if (out_valid && out_ready) begin
        if (kept_points.size() == 0) begin
          $error("unexpected kept point x=%0d y=%0d", out_kept_x, out_kept_y);
          fail_count++;
        end else begin
          want = kept_points.pop_front();
          if (out_kept_x !== want.x) begin
            $error("kept_x expected %0d got %0d", want.x, out_kept_x);
            fail_count++;
          end
          if (out_kept_y !== want.y) begin
            $error("kept_y expected %0d got %0d", want.y, out_kept_y);
            fail_count++;
          end
          if (out_kept_z !== want.z) begin
            $error("kept_z expected %0d got %0d", want.z, out_kept_z);
            fail_count++;
          end
          if (out_kept_intensity !== want.inten) begin
            $error("kept_intensity expected %0d got %0d", want.inten,
                   out_kept_intensity);
            fail_count++;
          end
        end
      end
    end
    kept_pending = kept_points.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the lidar point projection filter
// Loads a series of camera, region and image settings, streams directed and
// random points with random idle bursts on both channels, and lets the
// checker decide which points must come out.
// ----------------------------------------------------------------------------
module testbench;
  import lppf_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  reg_idx_t  cfg_index;
  cfg_word_t cfg_data;
  logic      in_valid;
  logic      in_ready;
  coord_t    in_point_x;
  coord_t    in_point_y;
  coord_t    in_point_z;
  inten_t    in_point_intensity;
  logic      out_valid;
  logic      out_ready;
  coord_t    out_kept_x;
  coord_t    out_kept_y;
  coord_t    out_kept_z;
  inten_t    out_kept_intensity;
  int        fail_count;
  int        kept_pending;
  bit        calm;          // no idling in the last part of the run
  logic      in_took;
  logic      out_took;
  int        quiet_cycles;
  int        ready_burst;

  lidar_point_project_filter DUT (.*);

  lppf_checker checker_i (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // register each transfer so the driver can see it at the next falling edge
  always @(posedge clk) begin
    in_took  <= rst_n && in_valid && in_ready;
    out_took <= rst_n && out_valid && out_ready;
  end

  // watchdog: end the run when nothing transfers for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: toggle ready in random bursts, hold it high once calm
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready = 1'b0;
      ready_burst = 0;
    end else if (calm) begin
      out_ready = 1'b1;
    end else if (ready_burst > 0) begin
      ready_burst--;
    end else begin
      out_ready = ($urandom_range(0, 2) != 0);
      ready_burst = $urandom_range(1, 10);
    end
  end

  task automatic write_reg(reg_idx_t idx, cfg_word_t value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // drain every kept point, then let the pipeline empty of dropped ones
  task automatic drain();
    in_valid = 1'b0;
    while (kept_pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // one point: optional idle burst, then hold valid until the transfer
  task automatic send_point(coord_t x, coord_t y, coord_t z, inten_t inten);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_point_x = x;
    in_point_y = y;
    in_point_z = z;
    in_point_intensity = inten;
    do @(negedge clk); while (!in_took);
  endtask

  function automatic cfg_word_t pair(int lo, int hi);
    return {hi[31:0], lo[31:0]};
  endfunction

  function automatic cfg_word_t roi_word(int xmin, int xmax, int ymin, int ymax);
    return {ymax[15:0], ymin[15:0], xmax[15:0], xmin[15:0]};
  endfunction

  // plausible camera: depth mostly positive, pixels centered on the image
  task automatic load_camera();
    int scale;
    int cols;
    int rows;
    int lo;
    scale = $urandom_range(1, 4);
    cols = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 800);
    rows = ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(1, 600);
    write_reg(REG_ROW0_AB, pair($urandom_range(0, 262144) - 131072,
                                $urandom_range(0, 65536) - 32768));
    write_reg(REG_ROW0_CD, pair($urandom_range(0, 65536) - 32768,
                                (cols / 2) * scale * 65536));
    write_reg(REG_ROW1_AB, pair($urandom_range(0, 65536) - 32768,
                                $urandom_range(0, 262144) - 131072));
    write_reg(REG_ROW1_CD, pair($urandom_range(0, 65536) - 32768,
                                (rows / 2) * scale * 65536));
    write_reg(REG_ROW2_AB, pair($urandom_range(0, 2048) - 1024,
                                $urandom_range(0, 2048) - 1024));
    write_reg(REG_ROW2_CD, pair($urandom_range(0, 8192) - 4096, scale * 65536));
    lo = $urandom_range(0, 30000);
    write_reg(REG_ROI, roi_word(-lo, $urandom_range(0, 30000),
                                -$urandom_range(0, 30000), $urandom_range(0, 30000)));
    write_reg(REG_IMAGE, {40'd0, 12'(rows), 12'(cols)});
  endtask

  task automatic load_raw();
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_t'(i), {$urandom, $urandom});
  endtask

  initial begin
    int n_sent;
    calm = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    in_point_intensity = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset registers: depth is zero, so nothing may pass
    send_point(16'sd0, 16'sd0, 16'sd0, 8'd0);
    send_point(16'sd32767, -16'sd32768, 16'sd100, 8'd255);
    drain();

    // unit depth, column = x/128: exercise the half-pixel ties
    write_reg(REG_ROW0_AB, pair(65536, 0));
    write_reg(REG_ROW0_CD, pair(0, 0));
    write_reg(REG_ROW1_AB, pair(0, 0));
    write_reg(REG_ROW1_CD, pair(0, 0));
    write_reg(REG_ROW2_AB, pair(0, 0));
    write_reg(REG_ROW2_CD, pair(0, 65536));
    write_reg(REG_ROI, roi_word(-32768, 32767, -32768, 32767));
    write_reg(REG_IMAGE, {40'd0, 12'd1, 12'd2});
    // out-of-range indexes must leave the registers alone
    write_reg(reg_idx_t'(8), '1);
    write_reg(reg_idx_t'(15), '0);
    send_point(16'sd64, 16'sd5, -16'sd32768, 8'd255);    // 0.5 -> 0, kept
    send_point(16'sd192, 16'sd5, 16'sd32767, 8'd1);      // 1.5 -> 2, dropped
    send_point(16'sd191, 16'sd5, 16'sd0, 8'd2);          // rounds to 1, kept
    send_point(-16'sd64, 16'sd5, 16'sd0, 8'd3);          // -0.5 -> 0, kept
    send_point(-16'sd65, 16'sd5, 16'sd0, 8'd4);          // -1, dropped
    send_point(16'sd63, -16'sd32768, 16'sd0, 8'd5);      // y on the bound
    send_point(16'sd10, 16'sd32767, 16'sd0, 8'd6);
    send_point(16'sd10, -16'sd32767, 16'sd7, 8'd170);
    drain();

    // negative depth
    write_reg(REG_ROW2_CD, pair(0, -65536));
    send_point(16'sd0, 16'sd0, 16'sd0, 8'd9);
    drain();

    // inverted region
    write_reg(REG_ROW2_CD, pair(0, 65536));
    write_reg(REG_ROI, roi_word(100, -100, -32768, 32767));
    send_point(16'sd0, 16'sd0, 16'sd0, 8'd10);
    drain();

    // zero image width
    write_reg(REG_ROI, roi_word(-32768, 32767, -32768, 32767));
    write_reg(REG_IMAGE, {40'd0, 12'd4095, 12'd0});
    send_point(16'sd0, 16'sd0, 16'sd0, 8'd11);
    drain();

    // pixel far outside the image: huge gain, tiny depth
    write_reg(REG_IMAGE, 64'hFF_FFFF);
    write_reg(REG_ROW0_AB, pair(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    write_reg(REG_ROW2_CD, pair(0, 1));
    send_point(16'sd32767, 16'sd1, 16'sd0, 8'd12);
    send_point(-16'sd32767, 16'sd1, 16'sd0, 8'd13);
    drain();

    // every register at all ones: region collapses, nothing passes
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_t'(i), '1);
    send_point(-16'sd100, -16'sd100, -16'sd100, 8'd14);
    send_point(16'sd0, -16'sd2, 16'sd0, 8'd15);
    drain();

    // random phases; the sender pauses at each until every kept point is out
    n_sent = 0;
    for (int phase = 0; phase < 11; phase++) begin
      if (phase == 10) calm = 1'b1;
      if (phase % 4 == 3) load_raw();
      else load_camera();
      for (int k = 0; k < 95; k++) begin
        if ($urandom_range(0, 1) == 0)
          send_point(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                     inten_t'($urandom));
        else
          send_point(coord_t'($urandom_range(0, 8000) - 4000),
                     coord_t'($urandom_range(0, 8000) - 4000),
                     coord_t'($urandom_range(0, 8000) - 4000), inten_t'($urandom));
        n_sent++;
      end
      drain();
    end

    in_valid = 1'b0;
    while (kept_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
